// ----- rtl/bab_pkg.sv -----
// ----------------------------------------------------------------------------
// bab_pkg
// Shared types, op codes and constants of the glow accumulate and blur engine.
// ----------------------------------------------------------------------------
package bab_pkg;

  localparam int CW   = 11;  // signed grid coordinate, room for a neighbor step
  localparam int OW   = 8;   // signed disc offset
  localparam int EW   = 14;  // signed line error term
  localparam int STW  = 10;  // splat weight
  localparam int DENW = 13;  // disc divisor r2 + 1
  localparam int NUMW = 23;  // disc dividend strength * (r2 - d + 1)
  localparam int DW   = 14;  // squared distance
  localparam int ACCW = 12;  // blur tap sum
  localparam int TAPS = 5;

  localparam logic [2:0] OP_CLEAR = 3'd0;
  localparam logic [2:0] OP_LINE  = 3'd1;
  localparam logic [2:0] OP_DISC  = 3'd2;
  localparam logic [2:0] OP_BLUR  = 3'd3;
  localparam logic [2:0] OP_READ  = 3'd4;

  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_DOUBLE = 2'd2;

  localparam logic [7:0] INTEN_SINGLE = 8'd158;
  localparam logic [7:0] INTEN_DOUBLE = 8'd220;
  localparam logic [7:0] CH_MAX       = 8'd255;

  typedef logic [2:0][7:0] rgb_t;

  typedef struct packed {
    logic [2:0]         op;
    logic signed [11:0] x_start;
    logic signed [11:0] y_start;
    logic signed [11:0] x_end;
    logic signed [11:0] y_end;
    logic [7:0]         disc_radius;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [9:0]         strength;
    logic [6:0]         cell_x;
    logic [5:0]         cell_y;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic       lit;
  } out_beat_t;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_DISPATCH,
    ST_CLR,
    ST_RD_DATA,
    ST_SP_RD,
    ST_SP_WR,
    ST_LN_NEXT,
    ST_DC_DIST,
    ST_DC_CHK,
    ST_DC_DIV,
    ST_DC_NEXT,
    ST_BL_TAP,
    ST_BL_WAIT,
    ST_BL_WR,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic load;
    logic pend_zero;
    logic pend_read;
    logic res_load;
    logic clr_start;
    logic clr_step;
    logic rd_issue;
    logic ln_setup;
    logic ln_step;
    logic nb_next;
    logic sp_rd;
    logic sp_wr;
    logic dc_setup;
    logic d_calc;
    logic div_start;
    logic wt_load;
    logic dc_step;
    logic bl_start;
    logic bl_tap;
    logic bl_wr;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       mode_off;
    logic       rd_out;
    logic       tgt_off;
    logic       nb_last;
    logic       line_end;
    logic       d_gt;
    logic       disc_last;
    logic       div_done;
    logic       clr_last;
    logic       tap_last;
    logic       bl_last;
  } sts_t;

  // binomial 1-4-6-4-1 weights
  function automatic logic [3:0] tap_coef(input logic [2:0] t);
    logic [3:0] c;
    case (t)
      3'd0, 3'd4: c = 4'd1;
      3'd1, 3'd3: c = 4'd4;
      3'd2:       c = 4'd6;
      default:    c = 4'd0;
    endcase
    return c;
  endfunction

endpackage

// ----- rtl/bab_div.sv -----
// ----------------------------------------------------------------------------
// bab_div
// Restoring divider, one quotient bit per cycle, for the disc falloff weight.
// ----------------------------------------------------------------------------
module bab_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [bab_pkg::NUMW-1:0]  num,
  input  logic [bab_pkg::DENW-1:0]  den,
  output logic                      done,
  output logic [bab_pkg::NUMW-1:0]  quot
);
  import bab_pkg::*;

  logic                busy_r;
  logic                done_r;
  logic [4:0]          cnt_r;
  logic [DENW-1:0]     rem_r;
  logic [NUMW-1:0]     q_r;
  logic [DENW-1:0]     den_r;
  logic [DENW:0]       trial;
  logic                q_bit;
  logic [DENW-1:0]     rem_nxt;

  always_comb begin
    trial   = {rem_r, q_r[NUMW-1]};
    q_bit   = (trial >= {1'b0, den_r});
    rem_nxt = q_bit ? DENW'(trial - {1'b0, den_r}) : DENW'(trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= 5'(NUMW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      q_r   <= num;
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[NUMW-2:0], q_bit};
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ----- rtl/bab_dp.sv -----
// ----------------------------------------------------------------------------
// bab_dp
// Datapath: glow grid and blur scratch memories, line stepper, disc walker,
// splat read-modify-write, blur tap accumulator and result registers.
// ----------------------------------------------------------------------------
module bab_dp #(
  parameter int GRID_W = 128,
  parameter int GRID_H = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  bab_pkg::in_beat_t   in_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_wdata,
  input  bab_pkg::cmd_t       cmd,
  output bab_pkg::sts_t       sts,
  output bab_pkg::out_beat_t  out_data
);
  import bab_pkg::*;

  localparam int CELLS = GRID_W * GRID_H;
  localparam int AW    = $clog2(CELLS);
  localparam int XW    = $clog2(GRID_W);
  localparam int YW    = $clog2(GRID_H);

  function automatic logic [AW-1:0] addr_of(input logic [AW-1:0] x, input logic [AW-1:0] y);
    return AW'(y * AW'(GRID_W)) + x;
  endfunction

  function automatic logic signed [CW-1:0] grid_coord(input logic signed [11:0] v);
    return CW'(v >>> 2);
  endfunction

  // memories
  logic [23:0] glow_mem [CELLS];
  logic [23:0] scr_mem  [CELLS];
  rgb_t        g_q_r, s_q_r;
  logic [AW-1:0] g_raddr, g_waddr, s_raddr;
  logic        g_we, s_we;
  rgb_t        g_wdata;

  // control state
  logic [1:0]    mode_r;
  logic [AW-1:0] cnt_r;

  // item and walkers
  in_beat_t               item_r;
  logic signed [CW-1:0]   cur_x_r, cur_y_r, end_x_r, end_y_r;
  logic signed [EW-1:0]   dx_r, dy_r, err_r;
  logic                   sx_neg_r, sy_neg_r;
  logic [2:0]             nb_r;
  logic signed [OW-1:0]   br_r, ox_r, oy_r;
  logic [DENW-1:0]        r2_r;
  logic [DW-1:0]          d_r;
  logic [STW-1:0]         wt_r;

  // blur
  logic [XW-1:0]          bx_r;
  logic [YW-1:0]          by_r;
  logic [2:0]             tap_r, tapi_r;
  logic                   tapv_r, pass_v_r, second_r;
  logic [2:0][ACCW-1:0]   acc_r;

  out_beat_t pend_r, out_r;

  // ---------------- line setup / step ----------------
  logic signed [CW-1:0] lx0, ly0, lx1, ly1;
  logic signed [EW-1:0] ddx, ddy, adx, ady;
  logic signed [EW:0]   e2;

  always_comb begin
    lx0 = grid_coord(item_r.x_start);
    ly0 = grid_coord(item_r.y_start);
    lx1 = grid_coord(item_r.x_end);
    ly1 = grid_coord(item_r.y_end);
    ddx = EW'(lx1) - EW'(lx0);
    ddy = EW'(ly1) - EW'(ly0);
    adx = ddx[EW-1] ? -ddx : ddx;
    ady = ddy[EW-1] ? -ddy : ddy;
    e2  = {err_r, 1'b0};
  end

  // ---------------- disc setup ----------------
  logic [6:0]          brv;
  logic [DENW-1:0]     r2m;
  logic [NUMW-1:0]     numer;
  logic [DENW-1:0]     den;
  logic                div_done;
  logic [NUMW-1:0]     div_q;

  always_comb begin
    brv   = 7'(item_r.disc_radius[7:2]) + 7'd1;
    r2m   = DENW'(DW'(r2_r) - d_r + DW'(1));
    numer = NUMW'(item_r.strength * r2m);
    den   = r2_r + DENW'(1);
  end

  bab_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (numer),
    .den   (den),
    .done  (div_done),
    .quot  (div_q)
  );

  // ---------------- splat target ----------------
  logic                 is_line;
  logic signed [OW-1:0] off_x, off_y;
  logic signed [CW-1:0] tgt_x, tgt_y;
  logic                 tgt_off;
  logic [AW-1:0]        tgt_addr;
  logic [STW-1:0]       sp_w;
  logic [7:0]           col [3];
  logic [17:0]          sp_prod [3];
  logic [10:0]          sp_sum [3];
  rgb_t                 sp_val;

  always_comb begin
    is_line = (item_r.op == OP_LINE);
    off_x   = '0;
    off_y   = '0;
    if (is_line) begin
      case (nb_r)
        3'd1:    off_x = -OW'(1);
        3'd2:    off_x =  OW'(1);
        3'd3:    off_y = -OW'(1);
        3'd4:    off_y =  OW'(1);
        default: ;
      endcase
    end else begin
      off_x = ox_r;
      off_y = oy_r;
    end
    tgt_x    = cur_x_r + CW'(off_x);
    tgt_y    = cur_y_r + CW'(off_y);
    tgt_off  = (tgt_x < 0) || (tgt_x >= GRID_W) || (tgt_y < 0) || (tgt_y >= GRID_H);
    tgt_addr = addr_of(AW'(tgt_x), AW'(tgt_y));
    // neighbors take a quarter weight
    sp_w     = is_line ? ((nb_r == 3'd0) ? item_r.strength : (item_r.strength >> 2)) : wt_r;
    col[0]   = item_r.red;
    col[1]   = item_r.green;
    col[2]   = item_r.blue;
    for (int k = 0; k < 3; k++) begin
      sp_prod[k] = 18'(col[k] * sp_w);
      sp_sum[k]  = {3'b000, g_q_r[k]} + {1'b0, sp_prod[k][17:8]};
      sp_val[k]  = (sp_sum[k] > 11'(CH_MAX)) ? CH_MAX : sp_sum[k][7:0];
    end
  end

  // ---------------- blur taps ----------------
  logic signed [XW+1:0] tx;
  logic signed [YW+1:0] ty;
  logic [XW-1:0]        tx_c;
  logic [YW-1:0]        ty_c;
  logic [AW-1:0]        tap_addr, cell_addr;
  rgb_t                 tap_q, bl_val;
  logic                 cell_last;

  always_comb begin
    tx = $signed({2'b00, bx_r}) + $signed({{(XW-1){1'b0}}, tap_r}) - (XW+2)'(2);
    ty = $signed({2'b00, by_r}) + $signed({{(YW-1){1'b0}}, tap_r}) - (YW+2)'(2);
    if (tx[XW+1])                          tx_c = '0;
    else if (tx > (XW+2)'(GRID_W - 1))     tx_c = XW'(GRID_W - 1);
    else                                   tx_c = tx[XW-1:0];
    if (ty[YW+1])                          ty_c = '0;
    else if (ty > (YW+2)'(GRID_H - 1))     ty_c = YW'(GRID_H - 1);
    else                                   ty_c = ty[YW-1:0];
    tap_addr  = pass_v_r ? addr_of(AW'(bx_r), AW'(ty_c)) : addr_of(AW'(tx_c), AW'(by_r));
    cell_addr = addr_of(AW'(bx_r), AW'(by_r));
    tap_q     = pass_v_r ? s_q_r : g_q_r;
    for (int k = 0; k < 3; k++) begin
      bl_val[k] = acc_r[k][ACCW-1:4];
    end
    cell_last = (bx_r == XW'(GRID_W - 1)) && (by_r == YW'(GRID_H - 1));
  end

  // ---------------- read op ----------------
  logic          rd_out;
  logic [AW-1:0] rd_addr;
  logic [7:0]    inten;
  logic [15:0]   rd_prod [3];

  always_comb begin
    rd_out  = (int'(item_r.cell_x) >= GRID_W) || (int'(item_r.cell_y) >= GRID_H);
    rd_addr = addr_of(AW'(item_r.cell_x), AW'(item_r.cell_y));
    inten   = (mode_r >= MODE_DOUBLE) ? INTEN_DOUBLE : INTEN_SINGLE;
    for (int k = 0; k < 3; k++) begin
      rd_prod[k] = 16'(g_q_r[k] * inten);
    end
  end

  // ---------------- memory ports ----------------
  always_comb begin
    g_raddr = tgt_addr;
    if (cmd.rd_issue)    g_raddr = rd_addr;
    else if (cmd.bl_tap) g_raddr = tap_addr;
    s_raddr = tap_addr;

    g_we    = cmd.clr_step || cmd.sp_wr || (cmd.bl_wr && pass_v_r);
    g_waddr = cell_addr;
    g_wdata = bl_val;
    if (cmd.clr_step) begin
      g_waddr = cnt_r;
      g_wdata = '0;
    end else if (cmd.sp_wr) begin
      g_waddr = tgt_addr;
      g_wdata = sp_val;
    end
    s_we = cmd.bl_wr && !pass_v_r;
  end

  always_ff @(posedge clk) begin
    if (g_we) glow_mem[g_waddr] <= g_wdata;
    g_q_r <= glow_mem[g_raddr];
  end

  always_ff @(posedge clk) begin
    if (s_we) scr_mem[cell_addr] <= bl_val;
    s_q_r <= scr_mem[s_raddr];
  end

  // ---------------- control registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_OFF;
      cnt_r  <= '0;
    end else begin
      if (cfg_we) mode_r <= cfg_wdata;
      if (cmd.clr_start)     cnt_r <= '0;
      else if (cmd.clr_step) cnt_r <= cnt_r + AW'(1);
    end
  end

  // ---------------- walker registers ----------------
  always_ff @(posedge clk) begin
    if (cmd.load) item_r <= in_data;

    if (cmd.ln_setup) begin
      cur_x_r  <= lx0;
      cur_y_r  <= ly0;
      end_x_r  <= lx1;
      end_y_r  <= ly1;
      dx_r     <= adx;
      dy_r     <= -ady;
      err_r    <= adx - ady;
      sx_neg_r <= !(lx0 < lx1);
      sy_neg_r <= !(ly0 < ly1);
      nb_r     <= '0;
    end else if (cmd.ln_step) begin
      if (e2 >= (EW+1)'(dy_r) && e2 <= (EW+1)'(dx_r)) begin
        err_r <= err_r + dy_r + dx_r;
      end else if (e2 >= (EW+1)'(dy_r)) begin
        err_r <= err_r + dy_r;
      end else if (e2 <= (EW+1)'(dx_r)) begin
        err_r <= err_r + dx_r;
      end
      if (e2 >= (EW+1)'(dy_r)) cur_x_r <= sx_neg_r ? cur_x_r - CW'(1) : cur_x_r + CW'(1);
      if (e2 <= (EW+1)'(dx_r)) cur_y_r <= sy_neg_r ? cur_y_r - CW'(1) : cur_y_r + CW'(1);
      nb_r <= '0;
    end else if (cmd.nb_next) begin
      nb_r <= nb_r + 3'd1;
    end

    if (cmd.dc_setup) begin
      cur_x_r <= grid_coord(item_r.x_start);
      cur_y_r <= grid_coord(item_r.y_start);
      br_r    <= $signed({1'b0, brv});
      ox_r    <= -$signed({1'b0, brv});
      oy_r    <= -$signed({1'b0, brv});
      r2_r    <= DENW'(brv * brv);
    end else if (cmd.dc_step) begin
      if (ox_r == br_r) begin
        ox_r <= -br_r;
        oy_r <= oy_r + OW'(1);
      end else begin
        ox_r <= ox_r + OW'(1);
      end
    end
    if (cmd.d_calc)  d_r  <= DW'(ox_r * ox_r) + DW'(oy_r * oy_r);
    if (cmd.wt_load) wt_r <= div_q[STW-1:0];
  end

  // ---------------- blur registers ----------------
  always_ff @(posedge clk) begin
    tapv_r <= cmd.bl_tap;
    tapi_r <= tap_r;
    if (cmd.bl_start) begin
      bx_r     <= '0;
      by_r     <= '0;
      tap_r    <= '0;
      pass_v_r <= 1'b0;
      second_r <= 1'b0;
    end else if (cmd.bl_tap) begin
      tap_r <= tap_r + 3'd1;
    end else if (cmd.bl_wr) begin
      tap_r <= '0;
      if (bx_r == XW'(GRID_W - 1)) begin
        bx_r <= '0;
        if (by_r == YW'(GRID_H - 1)) begin
          by_r     <= '0;
          pass_v_r <= !pass_v_r;
          if (pass_v_r) second_r <= 1'b1;
        end else begin
          by_r <= by_r + YW'(1);
        end
      end else begin
        bx_r <= bx_r + XW'(1);
      end
    end

    // data of a tap lands in the cycle after its read is issued
    if (cmd.bl_tap && tap_r == 3'd0) begin
      acc_r <= '0;
    end else if (tapv_r) begin
      for (int k = 0; k < 3; k++) begin
        acc_r[k] <= acc_r[k] + ACCW'(tap_q[k] * tap_coef(tapi_r));
      end
    end
  end

  // ---------------- result ----------------
  always_ff @(posedge clk) begin
    if (cmd.pend_zero) begin
      pend_r <= '0;
    end else if (cmd.pend_read) begin
      pend_r.red_out   <= rd_prod[0][15:8];
      pend_r.green_out <= rd_prod[1][15:8];
      pend_r.blue_out  <= rd_prod[2][15:8];
      pend_r.lit       <= |g_q_r;
    end
    if (cmd.res_load) out_r <= pend_r;
  end

  assign out_data = out_r;

  always_comb begin
    sts.op        = item_r.op;
    sts.mode_off  = (mode_r == MODE_OFF);
    sts.rd_out    = rd_out;
    sts.tgt_off   = tgt_off;
    sts.nb_last   = (nb_r == 3'(TAPS - 1));
    sts.line_end  = (cur_x_r == end_x_r) && (cur_y_r == end_y_r);
    sts.d_gt      = (d_r > DW'(r2_r));
    sts.disc_last = (ox_r == br_r) && (oy_r == br_r);
    sts.div_done  = div_done;
    sts.clr_last  = (cnt_r == AW'(CELLS - 1));
    sts.tap_last  = (tap_r == 3'(TAPS - 1));
    sts.bl_last   = cell_last && pass_v_r && (second_r || (mode_r < MODE_DOUBLE));
  end

endmodule

// ----- rtl/bab_ctrl.sv -----
// ----------------------------------------------------------------------------
// bab_ctrl
// Sequencer: decodes each op and steps the datapath through it, owns the
// input ready and the result valid.
// ----------------------------------------------------------------------------
module bab_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  input  bab_pkg::sts_t  sts,
  output bab_pkg::cmd_t  cmd
);
  import bab_pkg::*;

  state_t state_r, state_nxt;
  state_t after_splat;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    after_splat = (sts.op == OP_LINE) ? ST_LN_NEXT : ST_DC_NEXT;
    unique case (state_r)
      ST_INIT: begin
        // zero the grid after reset
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        cmd.pend_zero = 1'b1;
        if (sts.op == OP_CLEAR) begin
          cmd.clr_start = 1'b1;
          state_nxt     = ST_CLR;
        end else if (sts.mode_off) begin
          state_nxt = ST_DONE;
        end else begin
          unique case (sts.op)
            OP_LINE: begin
              cmd.ln_setup = 1'b1;
              state_nxt    = ST_SP_RD;
            end
            OP_DISC: begin
              cmd.dc_setup = 1'b1;
              state_nxt    = ST_DC_DIST;
            end
            OP_BLUR: begin
              cmd.bl_start = 1'b1;
              state_nxt    = ST_BL_TAP;
            end
            OP_READ: begin
              if (sts.rd_out) begin
                state_nxt = ST_DONE;
              end else begin
                cmd.rd_issue = 1'b1;
                state_nxt    = ST_RD_DATA;
              end
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) state_nxt = ST_DONE;
      end
      ST_RD_DATA: begin
        cmd.pend_read = 1'b1;
        state_nxt     = ST_DONE;
      end
      ST_SP_RD: begin
        if (sts.tgt_off) begin
          state_nxt = after_splat;
        end else begin
          cmd.sp_rd = 1'b1;
          state_nxt = ST_SP_WR;
        end
      end
      ST_SP_WR: begin
        cmd.sp_wr = 1'b1;
        state_nxt = after_splat;
      end
      ST_LN_NEXT: begin
        if (!sts.nb_last) begin
          cmd.nb_next = 1'b1;
          state_nxt   = ST_SP_RD;
        end else if (sts.line_end) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.ln_step = 1'b1;
          state_nxt   = ST_SP_RD;
        end
      end
      ST_DC_DIST: begin
        cmd.d_calc = 1'b1;
        state_nxt  = ST_DC_CHK;
      end
      ST_DC_CHK: begin
        if (sts.d_gt || sts.tgt_off) begin
          state_nxt = ST_DC_NEXT;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DC_DIV;
        end
      end
      ST_DC_DIV: begin
        if (sts.div_done) begin
          cmd.wt_load = 1'b1;
          state_nxt   = ST_SP_RD;
        end
      end
      ST_DC_NEXT: begin
        if (sts.disc_last) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.dc_step = 1'b1;
          state_nxt   = ST_DC_DIST;
        end
      end
      ST_BL_TAP: begin
        cmd.bl_tap = 1'b1;
        if (sts.tap_last) state_nxt = ST_BL_WAIT;
      end
      ST_BL_WAIT: begin
        state_nxt = ST_BL_WR;
      end
      ST_BL_WR: begin
        cmd.bl_wr = 1'b1;
        state_nxt = sts.bl_last ? ST_DONE : ST_BL_TAP;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.res_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_INIT;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.res_load)  out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- rtl/bloom_accumulate_blur_engine.sv -----
// ----------------------------------------------------------------------------
// bloom_accumulate_blur_engine
// Low-resolution RGB glow grid with line and disc splats, binomial blur and
// cell readout.
// ----------------------------------------------------------------------------
// One op is taken at a time and every op gives exactly one result beat; the
// next op is accepted as soon as the previous result sits in the output
// register. Every grid access goes through the single read and write port
// of the grid memory: a line splats the five-cell cross at each visited
// point, a disc walks each offset of its (2*br+1)^2 square and runs the
// 23-step divider for the falloff weight of each in-grid cell inside the
// radius, and blur filters each cell in both directions per pass, with a
// second pass in modes 2 and 3. After reset a clearing pass zeroes the grid
// before the first op is accepted; the mode register can be written during
// it.
module bloom_accumulate_blur_engine #(
  parameter int GRID_W = 128,
  parameter int GRID_H = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  bab_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bab_pkg::out_beat_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_wdata
);
  import bab_pkg::*;

  cmd_t cmd;
  sts_t sts;

  bab_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  bab_dp #(
    .GRID_W (GRID_W),
    .GRID_H (GRID_H)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

  // one op in flight: after an accepted beat the input closes
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while an op is in flight");

  // a new result never overwrites one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> (!out_valid || out_ready))
    else $error("result register overwritten");

  a_res_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |=> out_valid)
    else $error("loaded result not presented");

  // with glow off nothing reads back as lit
  a_off_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && sts.mode_off |-> !out_data.lit)
    else $error("lit result with glow mode off");

endmodule

// ----- test/tb_bloom_accumulate_blur_engine.sv -----
// ----------------------------------------------------------------------------
// tb_bloom_accumulate_blur_engine
// Self-checking bench for the glow grid engine: directed ops then random
// splat/read traffic over several glow modes. A shadow grid inside the bench
// predicts every result beat, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_bloom_accumulate_blur_engine;
  timeunit 1ns;
  timeprecision 1ps;
  import bab_pkg::*;

  localparam int GW = 128;
  localparam int GH = 64;
  localparam int CELLS = GW * GH;
  localparam int IDLE_LIMIT = 1500000;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_beat_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_beat_t out_data;
  logic      cfg_we;
  logic [1:0] cfg_wdata;

  bloom_accumulate_blur_engine #(.GRID_W(GW), .GRID_H(GH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  in_beat_t  pend_ops[$];
  out_beat_t exp_pixels[$];
  logic [7:0] glow[CELLS][3];
  logic [7:0] scratch[CELLS][3];
  logic [1:0] mode_sh;
  int errors;
  int idle_cycles;
  int burst_left, gap_left;
  int hold_left;
  bit hold_req;
  int stall_kind, stall_cnt;
  bit in_fire, out_fire;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  function automatic void splat_cell(input int x, input int y,
                                     input logic [7:0] col[3], input int w);
    int v;
    if (x < 0 || x >= GW || y < 0 || y >= GH) return;
    for (int k = 0; k < 3; k++) begin
      v = glow[y*GW+x][k] + ((col[k] * w) >> 8);
      glow[y*GW+x][k] = (v > 255) ? 8'd255 : v[7:0];
    end
  endfunction

  function automatic void walk_line(input int x0, input int y0, input int x1,
                                    input int y1, input logic [7:0] col[3],
                                    input int st);
    int dx, dy, sx, sy, err, e2;
    dx = (x1 > x0) ? x1 - x0 : x0 - x1;
    dy = -((y1 > y0) ? y1 - y0 : y0 - y1);
    sx = (x0 < x1) ? 1 : -1;
    sy = (y0 < y1) ? 1 : -1;
    err = dx + dy;
    forever begin
      splat_cell(x0, y0, col, st);
      splat_cell(x0-1, y0, col, st >> 2);
      splat_cell(x0+1, y0, col, st >> 2);
      splat_cell(x0, y0-1, col, st >> 2);
      splat_cell(x0, y0+1, col, st >> 2);
      if (x0 == x1 && y0 == y1) break;
      e2 = 2 * err;
      if (e2 >= dy) begin err += dy; x0 += sx; end
      if (e2 <= dx) begin err += dx; y0 += sy; end
    end
  endfunction

  function automatic void paint_disc(input int bx, input int by, input int rad,
                                     input logic [7:0] col[3], input int st);
    int br, r2, d;
    br = rad / 4 + 1;
    r2 = br * br;
    for (int y = -br; y <= br; y++)
      for (int x = -br; x <= br; x++) begin
        d = x*x + y*y;
        if (d <= r2) splat_cell(bx+x, by+y, col, (st * (r2 - d + 1)) / (r2 + 1));
      end
  endfunction

  function automatic logic [7:0] tap_sum(input int a, input int b, input int c,
                                         input int d, input int e);
    int s;
    s = a + 4*b + 6*c + 4*d + e;
    return s[11:4];
  endfunction

  function automatic void blur_pass();
    int m2, m1, p1, p2;
    for (int y = 0; y < GH; y++)
      for (int x = 0; x < GW; x++) begin
        m2 = (x > 1) ? x-2 : 0; m1 = (x > 0) ? x-1 : 0;
        p1 = (x < GW-1) ? x+1 : GW-1; p2 = (x < GW-2) ? x+2 : GW-1;
        for (int k = 0; k < 3; k++)
          scratch[y*GW+x][k] = tap_sum(glow[y*GW+m2][k], glow[y*GW+m1][k],
            glow[y*GW+x][k], glow[y*GW+p1][k], glow[y*GW+p2][k]);
      end
    for (int y = 0; y < GH; y++) begin
      m2 = (y > 1) ? y-2 : 0; m1 = (y > 0) ? y-1 : 0;
      p1 = (y < GH-1) ? y+1 : GH-1; p2 = (y < GH-2) ? y+2 : GH-1;
      for (int x = 0; x < GW; x++)
        for (int k = 0; k < 3; k++)
          glow[y*GW+x][k] = tap_sum(scratch[m2*GW+x][k], scratch[m1*GW+x][k],
            scratch[y*GW+x][k], scratch[p1*GW+x][k], scratch[p2*GW+x][k]);
    end
  endfunction

  // applies one op to the shadow grid and queues the expected result beat
  function automatic void predict_glow(input in_beat_t b);
    out_beat_t r;
    logic [7:0] col[3];
    int inten, c;
    r = '0;
    col[0] = b.red; col[1] = b.green; col[2] = b.blue;
    if (b.op == OP_CLEAR) begin
      for (int i = 0; i < CELLS; i++)
        for (int k = 0; k < 3; k++) glow[i][k] = 8'd0;
    end else if (mode_sh != MODE_OFF) begin
      case (b.op)
        OP_LINE: walk_line(int'(b.x_start) >>> 2, int'(b.y_start) >>> 2,
                           int'(b.x_end) >>> 2, int'(b.y_end) >>> 2, col, b.strength);
        OP_DISC: paint_disc(int'(b.x_start) >>> 2, int'(b.y_start) >>> 2,
                            b.disc_radius, col, b.strength);
        OP_BLUR: begin
          blur_pass();
          if (mode_sh >= MODE_DOUBLE) blur_pass();
        end
        OP_READ: begin
          if (b.cell_x < GW && b.cell_y < GH) begin
            c = b.cell_y * GW + b.cell_x;
            inten = (mode_sh >= MODE_DOUBLE) ? INTEN_DOUBLE : INTEN_SINGLE;
            r.red_out   = 8'((glow[c][0] * inten) >> 8);
            r.green_out = 8'((glow[c][1] * inten) >> 8);
            r.blue_out  = 8'((glow[c][2] * inten) >> 8);
            r.lit = (glow[c][0] | glow[c][1] | glow[c][2]) != 0;
          end
        end
        default: ;
      endcase
    end
    exp_pixels.push_back(r);
  endfunction

  function automatic int clamp12(input int v);
    return (v < -2048) ? -2048 : (v > 2047) ? 2047 : v;
  endfunction

  function automatic in_beat_t rand_op();
    in_beat_t b;
    logic [127:0] raw;
    int sel;
    raw = {$urandom, $urandom, $urandom, $urandom};
    b = raw[$bits(in_beat_t)-1:0];
    sel = $urandom_range(0, 999);
    if ($urandom_range(0, 9) < 7) begin
      // keep most splats near the visible grid
      b.x_start = 12'($urandom_range(0, 540) - 20);
      b.y_start = 12'($urandom_range(0, 280) - 20);
    end
    b.x_end = 12'(clamp12(int'(b.x_start) + $urandom_range(0, 64) - 32));
    b.y_end = 12'(clamp12(int'(b.y_start) + $urandom_range(0, 64) - 32));
    if (sel < 6) b.op = OP_CLEAR;
    else if (sel < 30) b.op = 3'(5 + $urandom_range(0, 2));
    else if (sel < 500) b.op = OP_READ;
    else if (sel < 800) begin
      b.op = OP_LINE;
      if ($urandom_range(0, 39) == 0) begin
        b.x_end = 12'($urandom); b.y_end = 12'($urandom);
      end
    end else begin
      b.op = OP_DISC;
      b.disc_radius = ($urandom_range(0, 29) == 0) ? 8'($urandom_range(0, 40))
                                                   : 8'($urandom_range(0, 15));
    end
    return b;
  endfunction

  function automatic in_beat_t mk(input logic [2:0] op, input int xs, input int ys,
                                  input int xe, input int ye, input int rad,
                                  input int col, input int st, input int cx,
                                  input int cy);
    in_beat_t b;
    b.op = op; b.x_start = 12'(xs); b.y_start = 12'(ys);
    b.x_end = 12'(xe); b.y_end = 12'(ye);
    b.disc_radius = 8'(rad); b.red = 8'(col); b.green = 8'(col >> 8);
    b.blue = 8'(col >> 16);
    b.strength = 10'(st); b.cell_x = 7'(cx); b.cell_y = 6'(cy);
    return b;
  endfunction

  // driver: bursts of beats with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      burst_left = 4;
      gap_left = 0;
    end else begin
      in_fire = in_valid && in_ready;
      if (in_fire) predict_glow(in_data);
      if (!in_valid || in_fire) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pend_ops.size() > 0) begin
          in_data <= pend_ops.pop_front();
          in_valid <= 1'b1;
          if (--burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor and receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      hold_left = 0;
      stall_kind = 0;
      stall_cnt = 0;
    end else begin
      out_fire = out_valid && out_ready;
      if (out_fire) begin
        if (exp_pixels.size() == 0) begin
          $display("unexpected result beat");
          errors++;
        end else begin
          out_beat_t e;
          e = exp_pixels.pop_front();
          if (out_data.red_out != e.red_out) report("red_out", out_data.red_out, e.red_out);
          if (out_data.green_out != e.green_out)
            report("green_out", out_data.green_out, e.green_out);
          if (out_data.blue_out != e.blue_out)
            report("blue_out", out_data.blue_out, e.blue_out);
          if (out_data.lit != e.lit) report("lit", out_data.lit, e.lit);
        end
      end
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 600;
      end
      if (--stall_cnt <= 0) begin
        stall_cnt = $urandom_range(16, 200);
        stall_kind = $urandom_range(0, 2);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (stall_kind)
          0: out_ready <= 1'b1;
          1: out_ready <= $urandom_range(0, 1);
          default: out_ready <= ($urandom_range(0, 9) != 0);
        endcase
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else if (++idle_cycles >= IDLE_LIMIT) begin
      $display("** bloom_accumulate_blur_engine: FAILED **");
      $finish;
    end
  end

  // sampled between edges so that driver updates have settled
  task automatic drain();
    do @(negedge clk);
    while (pend_ops.size() != 0 || in_valid || exp_pixels.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_mode(input logic [1:0] m);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    cfg_we <= 1'b0;
    mode_sh = m;
  endtask

  initial begin
    logic [1:0] modes[5];
    errors = 0;
    hold_req = 1'b0;
    mode_sh = MODE_OFF;
    for (int i = 0; i < CELLS; i++)
      for (int k = 0; k < 3; k++) glow[i][k] = 8'd0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 2'd0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    set_mode(2'd1);

    // directed: extremes, every op, saturation, off-grid and unused codes
    pend_ops.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pend_ops.push_back(mk(OP_LINE, 0, 0, 0, 0, 0, 24'hffffff, 1023, 0, 0));
    pend_ops.push_back(mk(OP_LINE, 0, 0, 0, 0, 0, 24'hffffff, 1023, 0, 0));
    pend_ops.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pend_ops.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 1, 0));
    pend_ops.push_back(mk(OP_LINE, -2048, -2048, 2047, 2047, 0, 24'h804020, 700, 0, 0));
    pend_ops.push_back(mk(OP_LINE, 511, 255, 400, 100, 0, 24'h0000ff, 0, 0, 0));
    pend_ops.push_back(mk(OP_DISC, -2048, -2048, 0, 0, 255, 24'hffffff, 1023, 0, 0));
    pend_ops.push_back(mk(OP_DISC, 200, 100, 0, 0, 0, 24'h112233, 512, 0, 0));
    pend_ops.push_back(mk(OP_DISC, 508, 252, 0, 0, 12, 24'hff00ff, 1023, 0, 0));
    pend_ops.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 127, 63));
    pend_ops.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 50, 25));
    pend_ops.push_back(mk(OP_BLUR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pend_ops.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 50, 25));
    pend_ops.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 1, 1));
    pend_ops.push_back(mk(3'd5, 100, 100, 0, 0, 9, 24'hffffff, 1023, 50, 25));
    pend_ops.push_back(mk(3'd6, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pend_ops.push_back(mk(3'd7, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    drain();
    set_mode(MODE_DOUBLE);
    pend_ops.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 127, 63));
    pend_ops.push_back(mk(OP_BLUR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pend_ops.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 50, 25));
    drain();
    set_mode(MODE_OFF);
    pend_ops.push_back(mk(OP_LINE, 0, 0, 40, 40, 0, 24'hffffff, 1023, 0, 0));
    pend_ops.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 0, 0, 50, 25));
    pend_ops.push_back(mk(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    drain();

    // random phases over all register settings
    modes = '{2'd1, 2'd2, 2'd0, 2'd3, 2'd1};
    foreach (modes[p]) begin
      set_mode(modes[p]);
      if (p == 1) hold_req = 1'b1;
      for (int i = 0; i < 305; i++) pend_ops.push_back(rand_op());
      drain();
    end

    if (errors == 0) $display("** bloom_accumulate_blur_engine: PASSED **");
    else $display("** bloom_accumulate_blur_engine: FAILED **");
    $finish;
  end

endmodule
